>>> design/assert_macros.svh
// Assertion shorthands for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, switched off while reset is held.
`define EEG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Concurrent check that also runs during reset.
`define EEG_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

>>> design/eeg_pkg.sv
package eeg_pkg;

  // Default sizes of the top level.
  localparam int WIDTH_DEF       = 32;
  localparam int STACK_DEPTH_DEF = 48;

  // Command from the sequencer to the shared arithmetic unit.
  typedef struct packed {
    logic start;
    logic mul;
  } unit_cmd_t;

  // Status from the shared arithmetic unit back to the sequencer.
  typedef struct packed {
    logic done;
    logic rem_zero;
  } unit_sts_t;

  // Stream data width: payload bits rounded up to whole bytes.
  function automatic int tdata_bits(input int bits);
    return ((bits + 7) / 8) * 8;
  endfunction

endpackage

>>> design/eeg_unit.sv
// Shared iterative arithmetic unit built around one subtractor.
// Divide: restoring division of magnitudes, one quotient bit per cycle,
// then signs applied so that the quotient truncates toward zero and the
// remainder takes the dividend's sign.
// Multiply-subtract: acc = opa - opb * opc modulo 2^(WIDTH+1), one
// multiplier bit per cycle, ending early once the remaining bits are zero.
module eeg_unit
  import eeg_pkg::*;
#(
  parameter int WIDTH = WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  unit_cmd_t        cmd,
  input  logic [WIDTH:0]   opa,
  input  logic [WIDTH:0]   opb,
  input  logic [WIDTH:0]   opc,
  output unit_sts_t        sts,
  output logic [WIDTH:0]   quot,
  output logic [WIDTH-1:0] rem,
  output logic [WIDTH:0]   acc
);

  localparam int W1 = WIDTH + 1;
  localparam int CW = $clog2(W1 + 1);

  logic          busy_r;
  logic          done_r;
  logic          mul_r;
  logic [CW-1:0] cnt_r;
  logic          neg_q_r;
  logic          neg_r_r;
  logic [W1-1:0] acc_r;
  logic [W1-1:0] mcand_r;
  logic [W1-1:0] mplier_r;

  logic [W1-1:0] acc_nxt;
  logic [W1-1:0] mcand_nxt;
  logic [W1-1:0] mplier_nxt;
  logic [W1:0]   sub_p;
  logic [W1:0]   sub_m;
  logic [W1:0]   diff;
  logic          div_ok;
  logic          last;
  logic [W1-1:0] mag_a;
  logic [W1-1:0] mag_b;
  logic [W1-1:0] q_mag;
  logic [WIDTH-1:0] r_mag;

  // Operand magnitudes for a division start.
  assign mag_a = opa[WIDTH] ? (W1'(0) - opa) : opa;
  assign mag_b = opb[WIDTH] ? (W1'(0) - opb) : opb;

  // The one shared subtractor and the step it takes.
  always_comb begin
    sub_p = mul_r ? {1'b0, acc_r} : {1'b0, acc_r[WIDTH-1:0], mplier_r[WIDTH-1]};
    sub_m = {1'b0, mcand_r};
    diff  = sub_p - sub_m;
    div_ok = !diff[W1];
    if (mul_r) begin
      acc_nxt    = mplier_r[0] ? diff[W1-1:0] : acc_r;
      mcand_nxt  = {mcand_r[W1-2:0], 1'b0};
      mplier_nxt = {1'b0, mplier_r[W1-1:1]};
      last       = (cnt_r == CW'(W1 - 1)) || (mplier_nxt == '0);
    end else begin
      acc_nxt    = div_ok ? diff[W1-1:0] : sub_p[W1-1:0];
      mcand_nxt  = mcand_r;
      mplier_nxt = {mplier_r[WIDTH-1:0], div_ok};
      last       = (cnt_r == CW'(WIDTH - 1));
    end
  end

  // Control: busy while iterating, done pulses one cycle at the end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      mul_r  <= 1'b0;
      cnt_r  <= '0;
    end else if (cmd.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      mul_r  <= cmd.mul;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CW'(1);
      if (last) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      if (cmd.mul) begin
        acc_r    <= opa;
        mcand_r  <= opb;
        mplier_r <= opc;
      end else begin
        acc_r    <= '0;
        mcand_r  <= {1'b0, mag_b[WIDTH-1:0]};
        mplier_r <= {1'b0, mag_a[WIDTH-1:0]};
        neg_q_r  <= opa[WIDTH] ^ opb[WIDTH];
        neg_r_r  <= opa[WIDTH];
      end
    end else if (busy_r) begin
      acc_r    <= acc_nxt;
      mcand_r  <= mcand_nxt;
      mplier_r <= mplier_nxt;
    end
  end

  // Signed results of a division, and the multiply-subtract result.
  assign q_mag = {1'b0, mplier_r[WIDTH-1:0]};
  assign r_mag = acc_r[WIDTH-1:0];
  assign quot  = neg_q_r ? (W1'(0) - q_mag) : q_mag;
  assign rem   = neg_r_r ? (WIDTH'(0) - r_mag) : r_mag;
  assign acc   = acc_r;

  assign sts.done     = done_r;
  assign sts.rem_zero = (r_mag == '0);

endmodule

>>> design/extended_euclid_gcd.sv
// Extended Euclid unit: gcd of two signed operands with Bezout coefficients,
// coef_first * value_n + coef_second * value_k = divisor_result.
// Input stream in_*: tdata carries value_n then value_k, one item per
// transfer. Result stream out_*: tdata carries divisor_result, coef_first,
// coef_second; tuser carries zero_divisor. One result per input item.
// The block takes one item at a time; in_tready is high only when idle.
// The forward pass pushes the quotient of each division onto a stack; the
// backward pass pops them and runs a multiply-subtract step for each, which
// ends sooner for small positive quotients. The next item can be taken in
// the cycle after the result is loaded. Both passes run on one shared
// subtractor that retires one bit per cycle; the quotient stack is a memory
// with a registered read port. A zero value_k goes from idle straight to the
// finish state, which loads its result.
// Results sit in an output register: if the receiver stalls, the finished
// result waits there and the block holds its next result until it drains.
// Reset is synchronous and active low; it empties the output register and
// returns the sequencer to idle.
module extended_euclid_gcd
  import eeg_pkg::*;
#(
  parameter int WIDTH       = WIDTH_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  localparam int IN_TW      = tdata_bits(2 * WIDTH),
  localparam int OUT_TW     = tdata_bits(3 * WIDTH + 2)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_TW-1:0]  in_tdata,   // value_n, value_k
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_TW-1:0] out_tdata,  // divisor_result, coef_first, coef_second
  output logic              out_tuser   // zero_divisor
);

  localparam int W1 = WIDTH + 1;
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_START,
    S_DIV_WAIT,
    S_POP,
    S_MUL_START,
    S_MUL_WAIT,
    S_FINISH
  } state_t;

  state_t            state_r;
  logic [WIDTH-1:0]  x_r;
  logic [WIDTH-1:0]  y_r;
  logic [W1-1:0]     a_r;
  logic [W1-1:0]     b_r;
  logic              zd_r;
  logic [DW-1:0]     depth_r;
  logic [W1-1:0]     q_rd_r;
  logic              out_valid_r;
  logic [OUT_TW-1:0] out_data_r;
  logic              out_zd_r;
  logic [W1-1:0]     stack_mem [STACK_DEPTH];

  logic [WIDTH-1:0]  in_n;
  logic [WIDTH-1:0]  in_k;
  logic              stack_full;
  logic              push;
  logic              pop;
  logic [DW-1:0]     depth_dec;
  unit_cmd_t         u_cmd;
  unit_sts_t         u_sts;
  logic [W1-1:0]     u_opa;
  logic [W1-1:0]     u_opb;
  logic [W1-1:0]     u_quot;
  logic [WIDTH-1:0]  u_rem;
  logic [W1-1:0]     u_acc;

  assign in_n = in_tdata[WIDTH-1:0];
  assign in_k = in_tdata[2*WIDTH-1:WIDTH];

  assign stack_full = (depth_r == DW'(STACK_DEPTH));
  assign push       = (state_r == S_DIV_WAIT) && u_sts.done;
  assign pop        = (state_r == S_POP) && (depth_r != '0);
  assign depth_dec  = depth_r - DW'(1);

  // Commands and operands for the shared unit.
  assign u_cmd.start = ((state_r == S_DIV_START) && !stack_full) ||
                       (state_r == S_MUL_START);
  assign u_cmd.mul   = (state_r == S_MUL_START);
  assign u_opa = u_cmd.mul ? a_r : {x_r[WIDTH-1], x_r};
  assign u_opb = u_cmd.mul ? b_r : {y_r[WIDTH-1], y_r};

  eeg_unit #(
    .WIDTH (WIDTH)
  ) u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (u_cmd),
    .opa   (u_opa),
    .opb   (u_opb),
    .opc   (q_rd_r),
    .sts   (u_sts),
    .quot  (u_quot),
    .rem   (u_rem),
    .acc   (u_acc)
  );

  // Quotient stack: push in the forward pass, registered pop going back.
  always_ff @(posedge clk) begin
    if (push) begin
      stack_mem[depth_r[AW-1:0]] <= u_quot;
    end
    if (pop) begin
      q_rd_r <= stack_mem[depth_dec[AW-1:0]];
    end
  end

  // Sequencer. The backward pass starts from a = b = 1 and pops every
  // quotient, which yields a = 1, b = 1 - q for the last one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // The output register empties on a transfer unless a new result loads.
      if (out_tready && (state_r != S_FINISH)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            x_r     <= in_n;
            y_r     <= in_k;
            depth_r <= '0;
            if (in_k == '0) begin
              zd_r    <= 1'b1;
              a_r     <= '0;
              b_r     <= '0;
              state_r <= S_FINISH;
            end else begin
              zd_r    <= 1'b0;
              a_r     <= W1'(1);
              b_r     <= W1'(1);
              state_r <= S_DIV_START;
            end
          end
        end
        S_DIV_START: begin
          if (stack_full) begin
            a_r     <= '0;
            b_r     <= '0;
            y_r     <= '0;
            state_r <= S_FINISH;
          end else begin
            state_r <= S_DIV_WAIT;
          end
        end
        S_DIV_WAIT: begin
          if (u_sts.done) begin
            depth_r <= depth_r + DW'(1);
            if (u_sts.rem_zero) begin
              state_r <= S_POP;
            end else begin
              x_r     <= y_r;
              y_r     <= u_rem;
              state_r <= S_DIV_START;
            end
          end
        end
        S_POP: begin
          if (depth_r == '0) begin
            state_r <= S_FINISH;
          end else begin
            depth_r <= depth_dec;
            state_r <= S_MUL_START;
          end
        end
        S_MUL_START: begin
          state_r <= S_MUL_WAIT;
        end
        S_MUL_WAIT: begin
          if (u_sts.done) begin
            a_r     <= b_r;
            b_r     <= u_acc;
            state_r <= S_POP;
          end
        end
        S_FINISH: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= OUT_TW'({b_r, a_r, y_r});
            out_zd_r    <= zd_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_zd_r;

endmodule

>>> design/eeg_checker.sv
`include "assert_macros.svh"

// Port-level checks on the extended Euclid unit.
module eeg_checker
  import eeg_pkg::*;
#(
  parameter int WIDTH = WIDTH_DEF,
  localparam int OUT_TW = tdata_bits(3 * WIDTH + 2)
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_TW-1:0] out_tdata,
  input logic              out_tuser
);

  logic              in_xfer;
  logic              out_stall;
  logic [OUT_TW:0]   out_word;

  assign in_xfer   = in_tvalid && in_tready;
  assign out_stall = out_tvalid && !out_tready;
  assign out_word  = {out_tuser, out_tdata};

  // A stalled result keeps its payload.
  `EEG_ASSERT(a_out_hold, out_stall |=> out_tvalid && $stable(out_word), "stalled result changed")

  // A zero divisor result carries all-zero data.
  `EEG_ASSERT(a_zero_div_data, out_tvalid && out_tuser |-> out_tdata == '0, "zero divisor data")

  // After a transfer in, the unit is busy on that item.
  `EEG_ASSERT(a_busy_after_in, in_xfer |=> !in_tready, "input ready right after a transfer")

  // Reset empties the output register.
  `EEG_ASSERT_RST(a_reset_empty, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind extended_euclid_gcd eeg_checker #(.WIDTH(WIDTH)) u_eeg_checker (.*);
